### rtl/apc_pkg.sv
// apc_pkg: shared widths, status codes and pipeline sideband types
// for the aspect portrait crop block; no dependencies
package apc_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int DW            = 24;              // field width
    localparam int ASPECT_FRAC   = 16;              // aspect register fraction bits
    localparam int SUMW          = DW + 1;          // head + feet sum
    localparam int SW4W          = DW + 3;          // subject size in quarter lsbs
    localparam int N1W           = 2 * DW;          // centred crop dividend
    localparam int N2W           = SW4W + DW;       // subject dividend
    localparam int Q1W           = DW;              // centred crop quotient bits
    localparam int Q2W           = SW4W;            // subject quotient bits

    typedef enum logic [1:0] {
        ST_SUBJECT = 2'd0,
        ST_CENTRED = 2'd1,
        ST_INVALID = 2'd2
    } status_t;

    // travels with the centred crop division
    typedef struct packed {
        logic                   inv;
        logic                   tiny;
        logic [DW-1:0]          w;
        logic [DW-1:0]          h;
        logic [SUMW-1:0]        sumx;
        logic [SUMW-1:0]        sumy;
        logic                   lgt;
        logic                   tol;
        logic                   sgt;
        logic                   ovf;
        logic [SW4W-1:0]        sw4;
        logic [SW4W-1:0]        sh4;
        logic [N2W-1:0]         n2;
        logic [DW-1:0]          d2;
    } d1_side_t;

    // travels with the subject division
    typedef struct packed {
        logic                   inv;
        logic                   tiny;
        logic [DW-1:0]          w;
        logic [DW-1:0]          h;
        logic [SUMW-1:0]        sumx;
        logic [SUMW-1:0]        sumy;
        logic                   lgt;
        logic                   tol;
        logic                   sgt;
        logic                   ovf;
        logic [SW4W-1:0]        sw4;
        logic [SW4W-1:0]        sh4;
        logic [Q1W-1:0]         q1;
    } d2_side_t;

endpackage

### rtl/apc_front.sv
// apc_front: three pipeline stages of span, product and compare work
// ahead of the dividers; depends on apc_pkg
module apc_front #(
    parameter int FRAC_BITS = apc_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [apc_pkg::DW-1:0]      aspect,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [apc_pkg::DW-1:0]      source_width,
    input  logic [apc_pkg::DW-1:0]      source_height,
    input  logic [apc_pkg::DW-1:0]      head_x,
    input  logic [apc_pkg::DW-1:0]      head_y,
    input  logic [apc_pkg::DW-1:0]      feet_x,
    input  logic [apc_pkg::DW-1:0]      feet_y,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [apc_pkg::N1W-1:0]     out_num,
    output logic [apc_pkg::DW-1:0]      out_den,
    output apc_pkg::d1_side_t           out_side
);

    localparam int DW       = apc_pkg::DW;
    localparam int SUMW     = apc_pkg::SUMW;
    localparam int SW4W     = apc_pkg::SW4W;
    localparam int N1W      = apc_pkg::N1W;
    localparam int N2W      = apc_pkg::N2W;
    localparam int Q2W      = apc_pkg::Q2W;
    localparam int SPAN_MAX = (1 << FRAC_BITS) / 1000;
    localparam logic [DW-1:0] AD_ONE = DW'(1 << apc_pkg::ASPECT_FRAC);

    typedef struct packed {
        logic               inv;
        logic               tiny;
        logic [DW-1:0]      w;
        logic [DW-1:0]      h;
        logic [DW-1:0]      an;
        logic [DW-1:0]      ad;
        logic [SUMW-1:0]    sumx;
        logic [SUMW-1:0]    sumy;
        logic [SW4W-1:0]    sw4;
        logic [SW4W-1:0]    sh4;
    } sa_t;

    typedef struct packed {
        sa_t                a;
        logic [N1W-1:0]     lhs;
        logic [N1W-1:0]     rhs;
        logic [N1W-1:0]     tolp;
        logic [N2W-1:0]     ms;
        logic [N2W-1:0]     mh;
    } sb_t;

    logic           va_reg, vb_reg, vc_reg;
    logic           ce_a, ce_b, ce_c;
    sa_t            a_reg, a_next;
    sb_t            b_reg, b_next;
    logic [N1W-1:0] n1_reg, n1_next;
    logic [DW-1:0]  d1_reg, d1_next;
    apc_pkg::d1_side_t side_reg, side_next;

    logic [SUMW-1:0] ex, ey;
    logic [DW-1:0]   dx, dy, span;
    logic [31:0]     tol_t;
    logic            lgt, sgt;
    logic [N2W-1:0]  n2;
    logic [DW-1:0]   d2;

    assign ce_c     = !vc_reg || out_ready;
    assign ce_b     = !vb_reg || ce_c;
    assign ce_a     = !va_reg || ce_b;
    assign in_ready = ce_a;

    // stage a: spans, centre sums, aspect terms
    always_comb
    begin
        ex   = {feet_x[DW-1], feet_x} - {head_x[DW-1], head_x};
        ey   = {feet_y[DW-1], feet_y} - {head_y[DW-1], head_y};
        dx   = ex[SUMW-1] ? DW'(-ex) : DW'(ex);
        dy   = ey[SUMW-1] ? DW'(-ey) : DW'(ey);
        span = (dx > dy) ? dx : dy;
        a_next.inv  = (source_width == '0) || (source_height == '0);
        a_next.tiny = span <= DW'(SPAN_MAX);
        a_next.w    = source_width;
        a_next.h    = source_height;
        a_next.an   = (aspect == '0) ? source_width : aspect;
        a_next.ad   = (aspect == '0) ? source_height : AD_ONE;
        a_next.sumx = {head_x[DW-1], head_x} + {feet_x[DW-1], feet_x};
        a_next.sumy = {head_y[DW-1], head_y} + {feet_y[DW-1], feet_y};
        a_next.sw4  = {1'b0, dx, 2'b00} + SW4W'(span);
        a_next.sh4  = {1'b0, dy, 2'b00} + SW4W'(span);
    end

    // stage b: products
    always_comb
    begin
        b_next.a    = a_reg;
        b_next.lhs  = N1W'(a_reg.w) * N1W'(a_reg.ad);
        b_next.rhs  = N1W'(a_reg.h) * N1W'(a_reg.an);
        b_next.tolp = N1W'(a_reg.h) * N1W'(a_reg.ad);
        b_next.ms   = N2W'(a_reg.sw4) * N2W'(a_reg.ad);
        b_next.mh   = N2W'(a_reg.sh4) * N2W'(a_reg.an);
    end

    // stage c: compares and divider operand select
    always_comb
    begin
        tol_t   = b_reg.tolp[N1W-1:apc_pkg::ASPECT_FRAC];
        lgt     = b_reg.lhs > b_reg.rhs;
        sgt     = b_reg.ms > b_reg.mh;
        n2      = sgt ? b_reg.ms : b_reg.mh;
        d2      = sgt ? b_reg.a.an : b_reg.a.ad;
        n1_next = lgt ? b_reg.rhs : b_reg.lhs;
        d1_next = lgt ? b_reg.a.ad : b_reg.a.an;
        side_next.inv  = b_reg.a.inv;
        side_next.tiny = b_reg.a.tiny;
        side_next.w    = b_reg.a.w;
        side_next.h    = b_reg.a.h;
        side_next.sumx = b_reg.a.sumx;
        side_next.sumy = b_reg.a.sumy;
        side_next.lgt  = lgt;
        side_next.tol  = lgt ? ({1'b0, b_reg.lhs} <= {1'b0, b_reg.rhs} + (N1W+1)'(tol_t))
                             : ({1'b0, b_reg.rhs} <= {1'b0, b_reg.lhs} + (N1W+1)'(tol_t));
        side_next.sgt  = sgt;
        side_next.ovf  = n2[N2W-1:Q2W] >= d2;
        side_next.sw4  = b_reg.a.sw4;
        side_next.sh4  = b_reg.a.sh4;
        side_next.n2   = n2;
        side_next.d2   = d2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            if (ce_a)
                va_reg <= in_valid;
            if (ce_b)
                vb_reg <= va_reg;
            if (ce_c)
                vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce_a)
            a_reg <= a_next;
        if (ce_b)
            b_reg <= b_next;
        if (ce_c)
        begin
            n1_reg   <= n1_next;
            d1_reg   <= d1_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = vc_reg;
    assign out_num   = n1_reg;
    assign out_den   = d1_reg;
    assign out_side  = side_reg;

endmodule

### rtl/apc_div.sv
// apc_div: pipelined restoring divider, one quotient bit per stage,
// carrying an opaque sideband; depends on nothing
module apc_div #(
    parameter int NW = 48,
    parameter int DW = 24,
    parameter int QW = 24,
    parameter int PW = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [NW-1:0]   in_num,
    input  logic [DW-1:0]   in_den,
    input  logic [PW-1:0]   in_side,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [QW-1:0]   out_quo,
    output logic [PW-1:0]   out_side
);

    localparam int XW = NW + DW;

    logic            v_reg   [QW];
    logic [NW-1:0]   rem_reg [QW];
    logic [DW-1:0]   den_reg [QW];
    logic [QW-1:0]   quo_reg [QW];
    logic [PW-1:0]   side_reg[QW];

    logic            v_in    [QW];
    logic [NW-1:0]   rem_in  [QW];
    logic [DW-1:0]   den_in  [QW];
    logic [QW-1:0]   quo_in  [QW];
    logic [PW-1:0]   side_in [QW];
    logic            rdy     [QW+1];

    assign rdy[QW]   = out_ready;
    assign in_ready  = rdy[0];
    assign out_valid = v_reg[QW-1];
    assign out_quo   = quo_reg[QW-1];
    assign out_side  = side_reg[QW-1];

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        localparam int B = QW - 1 - k;

        logic [XW-1:0] sub;
        logic [XW-1:0] diff;
        logic          ge;
        logic [NW-1:0] rem_next;
        logic [QW-1:0] quo_next;

        if (k == 0)
        begin : g_first
            assign v_in[k]    = in_valid;
            assign rem_in[k]  = in_num;
            assign den_in[k]  = in_den;
            assign quo_in[k]  = '0;
            assign side_in[k] = in_side;
        end
        else
        begin : g_next
            assign v_in[k]    = v_reg[k-1];
            assign rem_in[k]  = rem_reg[k-1];
            assign den_in[k]  = den_reg[k-1];
            assign quo_in[k]  = quo_reg[k-1];
            assign side_in[k] = side_reg[k-1];
        end

        assign rdy[k] = !v_reg[k] || rdy[k+1];

        always_comb
        begin
            sub         = XW'(den_in[k]) << B;
            ge          = XW'(rem_in[k]) >= sub;
            diff        = XW'(rem_in[k]) - sub;
            rem_next    = ge ? diff[NW-1:0] : rem_in[k];
            quo_next    = quo_in[k];
            quo_next[B] = ge;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (rdy[k])
                v_reg[k] <= v_in[k];
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k])
            begin
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= den_in[k];
                quo_reg[k]  <= quo_next;
                side_reg[k] <= side_in[k];
            end
        end
    end

endmodule

### rtl/apc_back.sv
// apc_back: size selection, fallback and placement in two stages,
// the second one being the output register; depends on apc_pkg
module apc_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [apc_pkg::Q2W-1:0]     q2,
    input  apc_pkg::d2_side_t           side,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [apc_pkg::DW-1:0]      crop_left,
    output logic [apc_pkg::DW-1:0]      crop_top,
    output logic [apc_pkg::DW-1:0]      crop_width,
    output logic [apc_pkg::DW-1:0]      crop_height,
    output apc_pkg::status_t            crop_status
);

    localparam int DW   = apc_pkg::DW;
    localparam int SUMW = apc_pkg::SUMW;
    localparam int SW4W = apc_pkg::SW4W;

    typedef struct packed {
        apc_pkg::status_t   status;
        logic [DW-1:0]      w;
        logic [DW-1:0]      h;
        logic [DW-1:0]      fw;
        logic [DW-1:0]      fh;
        logic [DW-1:0]      cw;
        logic [DW-1:0]      ch;
        logic [SUMW-1:0]    sumx;
        logic [SUMW-1:0]    sumy;
    } sp_t;

    logic           vp_reg, vo_reg;
    logic           ce_p, ce_o;
    sp_t            p_reg, p_next;

    logic [DW-1:0]   fw_raw, fh_raw, cw, ch;
    logic [SW4W-1:0] cw4, ch4;
    logic            big, fzero;

    logic [DW-1:0]   left_reg, left_next, top_reg, top_next;
    logic [DW-1:0]   width_reg, width_next, height_reg, height_next;
    apc_pkg::status_t status_reg;

    logic [SUMW:0]   vx, vy;
    logic [DW-1:0]   hix, hiy, px, py;

    assign ce_o     = !vo_reg || out_ready;
    assign ce_p     = !vp_reg || ce_o;
    assign in_ready = ce_p;

    // stage p: centred crop size, subject size, status
    always_comb
    begin
        fw_raw = side.w;
        fh_raw = side.h;
        if (!side.tol)
        begin
            if (side.lgt)
                fw_raw = side.q1;
            else
                fh_raw = side.q1;
        end
        fzero = (fw_raw == '0) || (fh_raw == '0);
        cw4   = side.sgt ? side.sw4 : q2;
        ch4   = side.sgt ? q2 : side.sh4;
        big   = side.ovf || (cw4 > SW4W'({side.w, 2'b00}))
                         || (ch4 > SW4W'({side.h, 2'b00}));
        cw    = big ? fw_raw : cw4[DW+1:2];
        ch    = big ? fh_raw : ch4[DW+1:2];
        p_next.w    = side.w;
        p_next.h    = side.h;
        p_next.fw   = fzero ? side.w : fw_raw;
        p_next.fh   = fzero ? side.h : fh_raw;
        p_next.cw   = cw;
        p_next.ch   = ch;
        p_next.sumx = side.sumx;
        p_next.sumy = side.sumy;
        if (side.inv)
            p_next.status = apc_pkg::ST_INVALID;
        else if (side.tiny || (cw == '0) || (ch == '0))
            p_next.status = apc_pkg::ST_CENTRED;
        else
            p_next.status = apc_pkg::ST_SUBJECT;
    end

    // stage o: corner placement and clamp
    always_comb
    begin
        vx  = {p_reg.sumx[SUMW-1], p_reg.sumx} - (SUMW+1)'(p_reg.cw);
        vy  = {p_reg.sumy[SUMW-1], p_reg.sumy} - (SUMW+1)'(p_reg.ch);
        hix = p_reg.w - p_reg.cw;
        hiy = p_reg.h - p_reg.ch;
        px  = (vx[SUMW] || (vx == '0)) ? '0 : vx[SUMW-1:1];
        py  = (vy[SUMW] || (vy == '0)) ? '0 : vy[SUMW-1:1];
        case (p_reg.status)
            apc_pkg::ST_SUBJECT:
            begin
                left_next   = (px > hix) ? hix : px;
                top_next    = (py > hiy) ? hiy : py;
                width_next  = p_reg.cw;
                height_next = p_reg.ch;
            end
            apc_pkg::ST_CENTRED:
            begin
                left_next   = (p_reg.w - p_reg.fw) >> 1;
                top_next    = (p_reg.h - p_reg.fh) >> 1;
                width_next  = p_reg.fw;
                height_next = p_reg.fh;
            end
            default:
            begin
                left_next   = '0;
                top_next    = '0;
                width_next  = '0;
                height_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (ce_p)
                vp_reg <= in_valid;
            if (ce_o)
                vo_reg <= vp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce_p)
            p_reg <= p_next;
        if (ce_o)
        begin
            left_reg   <= left_next;
            top_reg    <= top_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            status_reg <= p_reg.status;
        end
    end

    assign out_valid   = vo_reg;
    assign crop_left   = left_reg;
    assign crop_top    = top_reg;
    assign crop_width  = width_reg;
    assign crop_height = height_reg;
    assign crop_status = status_reg;

endmodule

### rtl/aspect_portrait_crop.sv
// aspect_portrait_crop: top level, aspect register and stream ports
// depends on apc_pkg, apc_front, apc_div and apc_back
//
// picks a crop rectangle of a set aspect around a head/feet subject
// - s_axis: one beat per request, tdata holds source size and the two points
// - m_axis: one beat per request, in request order, tdata holds the rectangle
// - cfg: write channel for target_aspect (unsigned Q8.16, zero = source aspect);
//   cfg_ready is always high, write it only while the pipeline is empty
// - the path from input beat to output beat runs through 3 front stages,
//   24 stages of the centred crop divider, 27 of the subject divider, 2 back
// - one beat per cycle sustained while m_axis is ready; every stage has its own valid bit and
//   loads whenever it is empty or the stage after it moves, so bubbles
//   collapse while the output waits
// - a stalled m_axis holds its beat; s_axis keeps taking beats until the
//   pipeline is full
// - reset clears every valid bit and sets target_aspect to zero
// - status: 0 subject crop, 1 centred fallback crop, 2 invalid source
module aspect_portrait_crop #(
    parameter int FRAC_BITS = apc_pkg::FRAC_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    // source_width, source_height, head_x, head_y, feet_x, feet_y
    input  logic [143:0]    s_axis_tdata,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    // crop_left, crop_top, crop_width, crop_height, crop_status, zero pad
    output logic [103:0]    m_axis_tdata,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [23:0]     cfg_data
);

    localparam int DW  = apc_pkg::DW;
    localparam int Q1W = apc_pkg::Q1W;
    localparam int Q2W = apc_pkg::Q2W;

    logic [DW-1:0] target_aspect_reg;

    // front to centred crop divider
    logic                       f_valid, f_ready;
    logic [apc_pkg::N1W-1:0]    f_num;
    logic [DW-1:0]              f_den;
    apc_pkg::d1_side_t          f_side;

    // centred crop divider to subject divider
    logic                       d1_valid, d1_ready;
    logic [Q1W-1:0]             d1_quo;
    apc_pkg::d1_side_t          d1_side;
    apc_pkg::d2_side_t          d2_in_side;

    // subject divider to back end
    logic                       d2_valid, d2_ready;
    logic [Q2W-1:0]             d2_quo;
    apc_pkg::d2_side_t          d2_side;

    logic [DW-1:0]              crop_left, crop_top, crop_width, crop_height;
    apc_pkg::status_t           crop_status;

    // configuration register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            target_aspect_reg <= '0;
        else if (cfg_valid)
            target_aspect_reg <= cfg_data;
    end

    apc_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .aspect        (target_aspect_reg),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .source_width  (s_axis_tdata[23:0]),
        .source_height (s_axis_tdata[47:24]),
        .head_x        (s_axis_tdata[71:48]),
        .head_y        (s_axis_tdata[95:72]),
        .feet_x        (s_axis_tdata[119:96]),
        .feet_y        (s_axis_tdata[143:120]),
        .out_valid     (f_valid),
        .out_ready     (f_ready),
        .out_num       (f_num),
        .out_den       (f_den),
        .out_side      (f_side)
    );

    // centred crop cut: quotient always fits the field width
    apc_div #(
        .NW (apc_pkg::N1W),
        .DW (DW),
        .QW (Q1W),
        .PW ($bits(apc_pkg::d1_side_t))
    ) u_div_centre (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_num    (f_num),
        .in_den    (f_den),
        .in_side   (f_side),
        .out_valid (d1_valid),
        .out_ready (d1_ready),
        .out_quo   (d1_quo),
        .out_side  (d1_side)
    );

    always_comb
    begin
        d2_in_side.inv  = d1_side.inv;
        d2_in_side.tiny = d1_side.tiny;
        d2_in_side.w    = d1_side.w;
        d2_in_side.h    = d1_side.h;
        d2_in_side.sumx = d1_side.sumx;
        d2_in_side.sumy = d1_side.sumy;
        d2_in_side.lgt  = d1_side.lgt;
        d2_in_side.tol  = d1_side.tol;
        d2_in_side.sgt  = d1_side.sgt;
        d2_in_side.ovf  = d1_side.ovf;
        d2_in_side.sw4  = d1_side.sw4;
        d2_in_side.sh4  = d1_side.sh4;
        d2_in_side.q1   = d1_quo;
    end

    // subject grow: quotient saturates through the overflow flag
    apc_div #(
        .NW (apc_pkg::N2W),
        .DW (DW),
        .QW (Q2W),
        .PW ($bits(apc_pkg::d2_side_t))
    ) u_div_subject (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d1_valid),
        .in_ready  (d1_ready),
        .in_num    (d1_side.n2),
        .in_den    (d1_side.d2),
        .in_side   (d2_in_side),
        .out_valid (d2_valid),
        .out_ready (d2_ready),
        .out_quo   (d2_quo),
        .out_side  (d2_side)
    );

    apc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (d2_valid),
        .in_ready    (d2_ready),
        .q2          (d2_quo),
        .side        (d2_side),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .crop_left   (crop_left),
        .crop_top    (crop_top),
        .crop_width  (crop_width),
        .crop_height (crop_height),
        .crop_status (crop_status)
    );

    assign m_axis_tdata = {6'b0, crop_status, crop_height, crop_width, crop_top, crop_left};

`ifndef SYNTHESIS
    // an invalid source gives an all-zero rectangle
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (crop_status == apc_pkg::ST_INVALID)
        |-> (crop_left == '0) && (crop_top == '0)
            && (crop_width == '0) && (crop_height == '0))
        else $error("invalid source beat with nonzero rectangle");

    // every valid source gives a rectangle with area
    a_nonzero_size: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (crop_status != apc_pkg::ST_INVALID)
        |-> (crop_width != '0) && (crop_height != '0))
        else $error("crop of zero size on a valid source");

    // with the output empty the whole pipeline can move
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output register empty");
`endif

endmodule
